### rtl/linear_search_move_to_head_core_assert.svh
// Assertion macros used by the checker file lsmth_checker.sv.
`ifndef LINEAR_SEARCH_MOVE_TO_HEAD_CORE_ASSERT_SVH
`define LINEAR_SEARCH_MOVE_TO_HEAD_CORE_ASSERT_SVH

// same-cycle implication
`define LSMTH_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lsmth assertion failed");

// next-cycle implication
`define LSMTH_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lsmth assertion failed");

`endif

### rtl/lsmth_pkg.sv
package lsmth_pkg;

	localparam int KIND_W  = 2;
	localparam int VALUE_W = 32;
	localparam int POS_W   = 6;
	localparam int CMP_W   = 7;
	localparam int OUT_W   = 16;

	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

	typedef struct packed {
		logic [CMP_W-1:0] comparisons;
		logic [POS_W-1:0] position;
		logic             found;
	} result_t;

endpackage

### rtl/lsmth_ram.sv
module lsmth_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/linear_search_move_to_head_core.sv
// Channel | Dir | Handshake          | Payload (lowest bit first)
// s       | in  | s_tvalid, s_tready | tdata: value[31:0]; tuser: kind[1:0]
// m       | out | m_tvalid, m_tready | tdata: found, position[5:0], comparisons[6:0], 2 zero bits
//
// Clear and append are done in ST_IDLE and give no item.
// A search reads one entry per cycle from the table RAM in ST_SCAN; on a hit away from
// entry 0 it then writes the swap back in ST_SWAP0 and ST_SWAP1.
// arst_n empties the table and drops any pending result; RAM contents are left as they are.
// A finished search result waits in the output register; s_tready stays low while a search
// result cannot be placed there.
module linear_search_move_to_head_core #(
	parameter int DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // value[31:0]
	input  logic [1:0]  s_tuser,  // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // found, position[5:0], comparisons[6:0], zero[1:0]
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_SWAP0 = 3'd2;
	localparam logic [2:0] ST_SWAP1 = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]                          state_q;
	logic [CW-1:0]                       count_q;
	logic                                m_valid_q;
	logic [lsmth_pkg::VALUE_W-1:0]       key_q;
	logic [lsmth_pkg::VALUE_W-1:0]       head_q;
	logic [CW-1:0]                       n_q;
	logic [CW-1:0]                       rd_idx_q;
	logic [CW-1:0]                       chk_idx_q;
	logic [AW-1:0]                       hit_idx_q;
	lsmth_pkg::result_t                  res_q;
	lsmth_pkg::result_t                  m_res_q;

	logic                                accept;
	logic                                out_free;
	logic                                match;
	logic                                last;
	logic [CW-1:0]                       chk_next;
	logic [31:0]                         hit_pos_w;
	logic [31:0]                         hit_cmp_w;
	logic [31:0]                         miss_cmp_w;

	logic                                ram_we;
	logic [AW-1:0]                       ram_waddr;
	logic [lsmth_pkg::VALUE_W-1:0]       ram_wdata;
	logic [AW-1:0]                       ram_raddr;
	logic [lsmth_pkg::VALUE_W-1:0]       ram_rdata;

	assign s_tready   = (state_q == ST_IDLE);
	assign accept     = s_tvalid && s_tready;
	assign out_free   = !m_valid_q || m_tready;
	assign match      = (ram_rdata == key_q);
	assign chk_next   = chk_idx_q + CW'(1);
	assign last       = (chk_next == n_q);
	assign hit_pos_w  = 32'(chk_idx_q);
	assign hit_cmp_w  = 32'(chk_next);
	assign miss_cmp_w = 32'(n_q);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, m_res_q.comparisons, m_res_q.position, m_res_q.found};

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = s_tdata;
		ram_raddr = rd_idx_q[AW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				ram_raddr = '0;
				if (accept && s_tuser == lsmth_pkg::KIND_APPEND && count_q < CW'(DEPTH)) begin
					ram_we = 1'b1;
				end
			end
			ST_SWAP0: begin
				ram_we    = 1'b1;
				ram_waddr = hit_idx_q;
				ram_wdata = head_q;
			end
			ST_SWAP1: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata = key_q;
			end
			default: begin
			end
		endcase
	end

	lsmth_ram #(
		.WIDTH(lsmth_pkg::VALUE_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (s_tuser)
							lsmth_pkg::KIND_CLEAR: count_q <= '0;
							lsmth_pkg::KIND_APPEND: begin
								if (count_q < CW'(DEPTH)) begin
									count_q <= count_q + CW'(1);
								end
							end
							lsmth_pkg::KIND_SEARCH: begin
								state_q <= (count_q == '0) ? ST_DONE : ST_SCAN;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (match) begin
						state_q <= (chk_idx_q == '0) ? ST_DONE : ST_SWAP0;
					end else if (last) begin
						state_q <= ST_DONE;
					end
				end
				ST_SWAP0: state_q <= ST_SWAP1;
				ST_SWAP1: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (state_q == ST_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			key_q     <= s_tdata;
			n_q       <= count_q;
			rd_idx_q  <= CW'(1);
			chk_idx_q <= '0;
			res_q     <= '0;
		end
		if (state_q == ST_SCAN) begin
			if (chk_idx_q == '0) begin
				head_q <= ram_rdata;
			end
			if (match) begin
				res_q.found       <= 1'b1;
				res_q.position    <= hit_pos_w[lsmth_pkg::POS_W-1:0];
				res_q.comparisons <= hit_cmp_w[lsmth_pkg::CMP_W-1:0];
				hit_idx_q         <= chk_idx_q[AW-1:0];
			end else if (last) begin
				res_q.found       <= 1'b0;
				res_q.position    <= '0;
				res_q.comparisons <= miss_cmp_w[lsmth_pkg::CMP_W-1:0];
			end
			rd_idx_q  <= rd_idx_q + CW'(1);
			chk_idx_q <= chk_next;
		end
		if (state_q == ST_DONE && out_free) begin
			m_res_q <= res_q;
		end
	end

endmodule

### rtl/lsmth_checker.sv
`include "linear_search_move_to_head_core_assert.svh"

module lsmth_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [31:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	logic       out_found;
	logic [5:0] out_pos;
	logic [6:0] out_cmp;
	logic       search_in;

	assign out_found = m_tdata[0];
	assign out_pos   = m_tdata[6:1];
	assign out_cmp   = m_tdata[13:7];
	assign search_in = s_tvalid && s_tready && s_tuser == lsmth_pkg::KIND_SEARCH;

	`LSMTH_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`LSMTH_ASSERT_NOW(a_miss_pos_zero, m_tvalid && !out_found, out_pos == 6'd0)
	`LSMTH_ASSERT_NOW(a_hit_count, m_tvalid && out_found, out_cmp[5:0] == out_pos + 6'd1)
	`LSMTH_ASSERT_NEXT(a_search_busy, search_in, !s_tready && !$isunknown(s_tdata) || !s_tready)

endmodule

bind linear_search_move_to_head_core lsmth_checker u_lsmth_checker (.*);

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int TABLE_DEPTH = 64;
	localparam int IDLE_LIMIT  = 2000;
	localparam int ITEM_TARGET = 550;
	localparam logic [lsmth_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

	class table_scoreboard;
		logic [lsmth_pkg::VALUE_W-1:0] slots [TABLE_DEPTH];
		int unsigned                   fill;
		lsmth_pkg::result_t            expected_q [$];
		int unsigned                   errors;
		int unsigned                   searches;
		int unsigned                   hits;
		int unsigned                   longest_scan;
		int unsigned                   full_loads;

		function new();
			fill = 0;
			errors = 0;
			searches = 0;
			hits = 0;
			longest_scan = 0;
			full_loads = 0;
			foreach (slots[i]) slots[i] = '0;
		endfunction

		function void note_input(logic [lsmth_pkg::KIND_W-1:0] kind,
			logic [lsmth_pkg::VALUE_W-1:0] value);
			lsmth_pkg::result_t            r;
			logic [lsmth_pkg::VALUE_W-1:0] held;
			int                            i;
			if (kind == lsmth_pkg::KIND_CLEAR) begin
				fill = 0;
			end else if (kind == lsmth_pkg::KIND_APPEND) begin
				if (fill < TABLE_DEPTH) begin
					slots[fill] = value;
					fill++;
					if (fill == TABLE_DEPTH) full_loads++;
				end
			end else if (kind == lsmth_pkg::KIND_SEARCH) begin
				r = '0;
				for (i = 0; i < fill; i++) begin
					r.comparisons = r.comparisons + 1'b1;
					if (slots[i] == value) begin
						r.found = 1'b1;
						r.position = i[lsmth_pkg::POS_W-1:0];
						break;
					end
				end
				if (r.found) begin
					held = slots[r.position];
					slots[r.position] = slots[0];
					slots[0] = held;
					hits++;
				end
				if (r.comparisons > longest_scan) longest_scan = r.comparisons;
				searches++;
				expected_q.push_back(r);
			end
		endfunction

		function void flag(string what);
			errors++;
			if (errors <= 10) $display("[%0t] mismatch: %s", $time, what);
		endfunction

		function void check_result(logic [lsmth_pkg::OUT_W-1:0] word);
			lsmth_pkg::result_t exp_r;
			lsmth_pkg::result_t got;
			if (expected_q.size() == 0) begin
				flag($sformatf("result %h with no search pending", word));
				return;
			end
			exp_r = expected_q.pop_front();
			got = lsmth_pkg::result_t'(word[$bits(lsmth_pkg::result_t)-1:0]);
			if (got.found !== exp_r.found)
				flag($sformatf("found exp %0d got %0d", exp_r.found, got.found));
			if (got.position !== exp_r.position)
				flag($sformatf("position exp %0d got %0d", exp_r.position, got.position));
			if (got.comparisons !== exp_r.comparisons)
				flag($sformatf("comparisons exp %0d got %0d", exp_r.comparisons,
					got.comparisons));
			if (word[lsmth_pkg::OUT_W-1:$bits(lsmth_pkg::result_t)] !== '0)
				flag($sformatf("pad bits exp 0 got %b",
					word[lsmth_pkg::OUT_W-1:$bits(lsmth_pkg::result_t)]));
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		function void close_out();
			if (expected_q.size() != 0)
				flag($sformatf("%0d search results never arrived", expected_q.size()));
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [31:0]        s_tdata;
	logic [1:0]         s_tuser;
	logic               m_tvalid;
	logic               m_tready;
	logic [15:0]        m_tdata;

	table_scoreboard    sb;
	bit                 calm;
	int unsigned        items_sent;

	linear_search_move_to_head_core #(
		.DEPTH(TABLE_DEPTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 80);
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			4, 5: return $urandom_range(0, 7);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_key();
		if (sb.fill > 0 && $urandom_range(0, 99) < 65)
			return sb.slots[$urandom_range(0, sb.fill - 1)];
		return pick_word();
	endfunction

	// entered and left at a falling edge
	task automatic send_item(logic [lsmth_pkg::KIND_W-1:0] kind, logic [31:0] value);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = kind;
		s_tdata = value;
		do @(posedge clk); while (!s_tready);
		sb.note_input(kind, value);
		if (kind != KIND_UNUSED) items_sent++;
		@(negedge clk);
	endtask

	task automatic run_phase();
		int unsigned loads;
		int unsigned probes;
		int unsigned r;
		int          i;
		calm = ($urandom_range(0, 99) < 20);
		if (sb.fill == TABLE_DEPTH || $urandom_range(0, 99) < 70)
			send_item(lsmth_pkg::KIND_CLEAR, $urandom);
		loads = ($urandom_range(0, 99) < 10) ? TABLE_DEPTH + $urandom_range(1, 3)
			: $urandom_range(1, 12);
		for (i = 0; i < loads; i++)
			send_item(lsmth_pkg::KIND_APPEND, pick_word());
		if (sb.fill == TABLE_DEPTH)
			send_item(lsmth_pkg::KIND_SEARCH, sb.slots[TABLE_DEPTH-1]);
		probes = $urandom_range(4, 15);
		for (i = 0; i < probes; i++) begin
			r = $urandom_range(0, 99);
			if (r < 85) send_item(lsmth_pkg::KIND_SEARCH, pick_key());
			else if (r < 92) send_item(lsmth_pkg::KIND_APPEND, pick_word());
			else if (r < 96) send_item(KIND_UNUSED, $urandom);
			else send_item(lsmth_pkg::KIND_CLEAR, $urandom);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
	end

	initial begin
		int unsigned g;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			g = pick_gap();
			if (g > 0) begin
				m_tready = 1'b0;
				repeat (g) @(negedge clk);
			end
			m_tready = 1'b1;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	end

	initial begin
		int unsigned idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
			else idle++;
		end
		$display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
		$display("linear_search_move_to_head_core regression: fail");
		$finish;
	end

	initial begin
		sb = new();
		calm = 1'b0;
		items_sent = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = lsmth_pkg::KIND_CLEAR;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_item(lsmth_pkg::KIND_SEARCH, 32'h0000_0000);
		send_item(lsmth_pkg::KIND_APPEND, 32'h8000_0000);
		send_item(lsmth_pkg::KIND_APPEND, 32'h7FFF_FFFF);
		send_item(lsmth_pkg::KIND_APPEND, 32'h0000_0000);
		send_item(lsmth_pkg::KIND_APPEND, 32'hFFFF_FFFF);
		send_item(lsmth_pkg::KIND_APPEND, 32'hAAAA_AAAA);
		send_item(lsmth_pkg::KIND_APPEND, 32'h5555_5555);
		send_item(lsmth_pkg::KIND_APPEND, 32'h7FFF_FFFF);
		send_item(lsmth_pkg::KIND_SEARCH, 32'h8000_0000);
		send_item(lsmth_pkg::KIND_SEARCH, 32'hFFFF_FFFF);
		send_item(lsmth_pkg::KIND_SEARCH, 32'hFFFF_FFFF);
		send_item(lsmth_pkg::KIND_SEARCH, 32'h7FFF_FFFF);
		send_item(lsmth_pkg::KIND_SEARCH, 32'h5555_5555);
		send_item(lsmth_pkg::KIND_SEARCH, 32'h1234_5678);
		send_item(KIND_UNUSED, 32'hFFFF_FFFF);
		send_item(lsmth_pkg::KIND_SEARCH, 32'h0000_0000);
		send_item(lsmth_pkg::KIND_CLEAR, 32'hFFFF_FFFF);
		send_item(lsmth_pkg::KIND_SEARCH, 32'h8000_0000);
		send_item(lsmth_pkg::KIND_APPEND, 32'h0000_0001);
		send_item(lsmth_pkg::KIND_SEARCH, 32'h0000_0001);
		send_item(lsmth_pkg::KIND_SEARCH, 32'h0000_0002);

		while (items_sent < ITEM_TARGET) run_phase();
		s_tvalid = 1'b0;
		calm = 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (TABLE_DEPTH + 8) @(posedge clk);
		sb.close_out();

		$display("sent %0d items; %0d searches, %0d hits, %0d misses", items_sent,
			sb.searches, sb.hits, sb.searches - sb.hits);
		$display("longest scan %0d comparisons; table filled %0d times; %0d mismatches",
			sb.longest_scan, sb.full_loads, sb.errors);
		if (sb.errors == 0) begin
			$display("linear_search_move_to_head_core regression: pass");
		end else begin
			$display("linear_search_move_to_head_core regression: fail");
		end
		$finish;
	end

endmodule

### sim.f
+incdir+rtl
rtl/lsmth_pkg.sv
rtl/lsmth_ram.sv
rtl/linear_search_move_to_head_core.sv
rtl/lsmth_checker.sv
sim/tb_top.sv
